>>> hdl/gnomonic_projection_unit_assert.svh
// assertion macros for the gnomonic projection unit
`ifndef GNOMONIC_PROJECTION_UNIT_ASSERT_SVH
`define GNOMONIC_PROJECTION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GNP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("gnp assertion failed");
`define GNP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gnp assertion failed");
`define GNP_ASSERT_LATENCY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (ante) |-> ##(gnp_pkg::TOTAL_LAT) (cons)) else $error("gnp latency check failed");
`else
`define GNP_ASSERT_ALWAYS(label, cond)
`define GNP_ASSERT_IMPLY(label, ante, cons)
`define GNP_ASSERT_LATENCY(label, ante, cons)
`endif
`endif

>>> hdl/gnp_pkg.sv
package gnp_pkg;

  // angle format and iteration count
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STAGES = 24;

  // field widths
  localparam int LAT_W = 24;
  localparam int LON_W = 25;
  localparam int OUT_W = 40;
  localparam int RAD_W = 24;
  localparam int STAT_W = 2;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // internal widths
  localparam int DLON_W = LON_W + 1;
  localparam int ANG_W = ((ANGLE_FRAC_BITS + 10) > DLON_W ?
                          (ANGLE_FRAC_BITS + 10) : DLON_W) + 1;
  localparam int Z_W = 41;
  localparam int Z_SHIFT = 32 - ANGLE_FRAC_BITS;
  localparam int XY_W = 34;
  localparam int PROD_W = 2 * XY_W;
  localparam int NQ_W = 40;
  localparam int MAG_W = NQ_W;
  localparam int NUM_W = RAD_W + MAG_W;
  localparam int N_W = NUM_W + 2;
  localparam int DV_W = MAG_W + 1;

  // queue and pipeline depths
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int CORD_LAT = CORDIC_STAGES + 1;
  localparam int MUL_LAT = 4;
  localparam int DIV_LAT = OUT_W + 1;
  localparam int TOTAL_LAT = CORD_LAT + MUL_LAT + DIV_LAT + 3;

  // angle constants in input units
  localparam logic signed [ANG_W-1:0] QUARTER_ANG = ANG_W'(longint'(90) <<< ANGLE_FRAC_BITS);
  localparam logic signed [ANG_W-1:0] HALF_ANG = ANG_W'(longint'(180) <<< ANGLE_FRAC_BITS);
  localparam logic signed [ANG_W-1:0] FULL_ANG = ANG_W'(longint'(360) <<< ANGLE_FRAC_BITS);

  // cordic gain compensation, q30
  localparam logic signed [XY_W-1:0] CORDIC_K = XY_W'(652032874);
  localparam longint RAD2DEG_Q24 = 961263669;

  // rounding offsets
  localparam logic signed [PROD_W-1:0] RND30 = PROD_W'(longint'(1) <<< 29);
  localparam logic signed [PROD_W-1:0] RND24 = PROD_W'(longint'(1) <<< 23);

  // saturation limits as magnitudes
  localparam logic [OUT_W-1:0] LIM_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] LIM_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  // register map
  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(6371000);
  localparam logic REG_RADIUS = 1'b0;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_DEN = 2'd1,
    STAT_POLE     = 2'd2,
    STAT_SAT      = 2'd3
  } gnp_status_t;

  // word passed from front to back
  typedef struct packed {
    logic signed [Z_W-1:0] z0;
    logic signed [Z_W-1:0] z1;
    logic signed [Z_W-1:0] zd;
    logic                  neg0;
    logic                  neg1;
    logic                  negd;
    logic                  flip;
    logic                  pole;
  } gnp_item_t;

  // flags riding alongside the dividers
  typedef struct packed {
    logic pole;
    logic dz;
    logic neg_e;
    logic neg_n;
  } gnp_tag_t;

  // long division of 2^e by d, evaluated at elaboration
  function automatic longint unsigned pow2_quot(input int e, input longint unsigned d);
    longint unsigned rem;
    longint unsigned q;
    rem = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], (b == e)};
      q = {q[62:0], 1'b0};
      if (rem >= d) begin
        rem = rem - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctangent of 2^-stage in q32 degrees, evaluated at elaboration
  function automatic longint atan_deg_q32(input int stage);
    longint sum;
    longint rad32;
    longint unsigned term;
    int e;
    sum = 0;
    if (stage == 0) begin
      return longint'(45) <<< 32;
    end
    for (int k = 0; k < 32; k++) begin
      e = 62 - stage * (2 * k + 1);
      if (e >= 0) begin
        term = pow2_quot(e, longint'(2 * k + 1));
        if (k[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
    end
    rad32 = (sum + (longint'(1) <<< 29)) >>> 30;
    return (rad32 * RAD2DEG_Q24 + (longint'(1) <<< 23)) >>> 24;
  endfunction

endpackage

>>> hdl/gnp_front.sv
module gnp_front (
  input  logic                               start,
  input  logic                               full,
  input  logic signed [gnp_pkg::LAT_W-1:0]   centre_lat,
  input  logic signed [gnp_pkg::LON_W-1:0]   centre_lon,
  input  logic signed [gnp_pkg::LAT_W-1:0]   point_lat,
  input  logic signed [gnp_pkg::LON_W-1:0]   point_lon,
  output logic                               push,
  output logic                               busy,
  output gnp_pkg::gnp_item_t                 item
);

  // wrap into [-180, 180)
  function automatic logic signed [gnp_pkg::ANG_W-1:0] wrap_angle(
    input logic signed [gnp_pkg::ANG_W-1:0] a);
    logic signed [gnp_pkg::ANG_W-1:0] r;
    r = a;
    if (a >= gnp_pkg::HALF_ANG) begin
      r = a - gnp_pkg::FULL_ANG;
    end else if (a < -gnp_pkg::HALF_ANG) begin
      r = a + gnp_pkg::FULL_ANG;
    end
    return r;
  endfunction

  // angle beyond a quarter turn folds by a half turn
  function automatic logic beyond_quarter(input logic signed [gnp_pkg::ANG_W-1:0] a);
    return (a > gnp_pkg::QUARTER_ANG) || (a < -gnp_pkg::QUARTER_ANG);
  endfunction

  // folded angle in q32 degrees
  function automatic logic signed [gnp_pkg::Z_W-1:0] fold_z(
    input logic signed [gnp_pkg::ANG_W-1:0] a);
    logic signed [gnp_pkg::ANG_W-1:0] b;
    b = a;
    if (a > gnp_pkg::QUARTER_ANG) begin
      b = a - gnp_pkg::HALF_ANG;
    end else if (a < -gnp_pkg::QUARTER_ANG) begin
      b = a + gnp_pkg::HALF_ANG;
    end
    return gnp_pkg::Z_W'(b) <<< gnp_pkg::Z_SHIFT;
  endfunction

  logic signed [gnp_pkg::ANG_W-1:0] lat0;
  logic signed [gnp_pkg::ANG_W-1:0] lat1;
  logic signed [gnp_pkg::ANG_W-1:0] dlon;

  // reduce the three angles
  always_comb begin
    lat0 = wrap_angle(gnp_pkg::ANG_W'(centre_lat));
    lat1 = wrap_angle(gnp_pkg::ANG_W'(point_lat));
    dlon = wrap_angle(gnp_pkg::ANG_W'(point_lon) - gnp_pkg::ANG_W'(centre_lon));
  end

  // classify and build the queue word
  always_comb begin
    item.z0   = fold_z(lat0);
    item.z1   = fold_z(lat1);
    item.zd   = fold_z(dlon);
    item.neg0 = beyond_quarter(lat0);
    item.neg1 = beyond_quarter(lat1);
    item.negd = beyond_quarter(dlon);
    item.flip = beyond_quarter(lat0);
    item.pole = (lat0 == gnp_pkg::QUARTER_ANG) || (lat0 == -gnp_pkg::QUARTER_ANG);
  end

  assign busy = full;
  assign push = start && !full;

endmodule

>>> hdl/gnp_queue.sv
module gnp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               pop,
  input  gnp_pkg::gnp_item_t din,
  output gnp_pkg::gnp_item_t dout,
  output logic               dout_valid,
  output logic               empty,
  output logic               full
);

  gnp_pkg::gnp_item_t mem [gnp_pkg::QUEUE_DEPTH];
  logic [gnp_pkg::QPTR_W-1:0] wr_ptr;
  logic [gnp_pkg::QPTR_W-1:0] rd_ptr;
  logic [gnp_pkg::QPTR_W:0]   count;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
      dout_valid <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count      <= count + (gnp_pkg::QPTR_W+1)'(push) - (gnp_pkg::QPTR_W+1)'(pop);
      dout_valid <= pop;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // registered read of the oldest word
  always_ff @(posedge clk) begin
    if (pop) begin
      dout <= mem[rd_ptr];
    end
  end

  assign empty = (count == '0);
  assign full  = (count == (gnp_pkg::QPTR_W+1)'(gnp_pkg::QUEUE_DEPTH));

endmodule

>>> hdl/gnp_cordic.sv
module gnp_cordic (
  input  logic                             clk,
  input  logic signed [gnp_pkg::Z_W-1:0]   angle,
  input  logic                             neg,
  output logic signed [gnp_pkg::XY_W-1:0]  sin_val,
  output logic signed [gnp_pkg::XY_W-1:0]  cos_val
);

  logic signed [gnp_pkg::XY_W-1:0] xs [gnp_pkg::CORDIC_STAGES];
  logic signed [gnp_pkg::XY_W-1:0] ys [gnp_pkg::CORDIC_STAGES];
  logic signed [gnp_pkg::Z_W-1:0]  zs [gnp_pkg::CORDIC_STAGES];
  logic                            ns [gnp_pkg::CORDIC_STAGES];

  // one micro-rotation per stage
  for (genvar s = 0; s < gnp_pkg::CORDIC_STAGES; s++) begin : g_stage
    localparam logic signed [gnp_pkg::Z_W-1:0] ATAN = gnp_pkg::Z_W'(gnp_pkg::atan_deg_q32(s));
    logic signed [gnp_pkg::XY_W-1:0] xp;
    logic signed [gnp_pkg::XY_W-1:0] yp;
    logic signed [gnp_pkg::Z_W-1:0]  zp;
    logic                            np;

    if (s == 0) begin : g_first
      assign xp = gnp_pkg::CORDIC_K;
      assign yp = '0;
      assign zp = angle;
      assign np = neg;
    end else begin : g_rest
      assign xp = xs[s-1];
      assign yp = ys[s-1];
      assign zp = zs[s-1];
      assign np = ns[s-1];
    end

    always_ff @(posedge clk) begin
      if (!zp[gnp_pkg::Z_W-1]) begin
        xs[s] <= xp - (yp >>> s);
        ys[s] <= yp + (xp >>> s);
        zs[s] <= zp - ATAN;
      end else begin
        xs[s] <= xp + (yp >>> s);
        ys[s] <= yp - (xp >>> s);
        zs[s] <= zp + ATAN;
      end
      ns[s] <= np;
    end
  end

  // undo the half-turn fold
  always_ff @(posedge clk) begin
    sin_val <= ns[gnp_pkg::CORDIC_STAGES-1] ? -ys[gnp_pkg::CORDIC_STAGES-1]
                                             : ys[gnp_pkg::CORDIC_STAGES-1];
    cos_val <= ns[gnp_pkg::CORDIC_STAGES-1] ? -xs[gnp_pkg::CORDIC_STAGES-1]
                                             : xs[gnp_pkg::CORDIC_STAGES-1];
  end

endmodule

>>> hdl/gnp_div.sv
module gnp_div (
  input  logic                          clk,
  input  logic [gnp_pkg::NUM_W-1:0]     num,
  input  logic [gnp_pkg::MAG_W-1:0]     den,
  output logic [gnp_pkg::OUT_W-1:0]     quot,
  output logic                          big
);

  localparam int QW = gnp_pkg::OUT_W;
  localparam int DW = gnp_pkg::DV_W;
  localparam int HI_W = gnp_pkg::N_W - QW;

  logic [gnp_pkg::N_W-1:0] n_full;
  logic [DW-1:0]           dv_full;

  logic [DW-1:0] rem [QW+1];
  logic [QW-1:0] nlo [QW+1];
  logic [QW-1:0] qq  [QW+1];
  logic [DW-1:0] dv  [QW+1];
  logic          bg  [QW+1];

  // round half up: (2*num + den) / (2*den)
  always_comb begin
    n_full  = gnp_pkg::N_W'({num, 1'b0}) + gnp_pkg::N_W'(den);
    dv_full = {den, 1'b0};
  end

  // quotient too wide for the output is caught up front
  always_ff @(posedge clk) begin
    rem[0] <= {{(DW-HI_W){1'b0}}, n_full[gnp_pkg::N_W-1:QW]};
    nlo[0] <= n_full[QW-1:0];
    qq[0]  <= '0;
    dv[0]  <= dv_full;
    bg[0]  <= (gnp_pkg::N_W+QW)'(n_full) >= {dv_full, {QW{1'b0}}};
  end

  // one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_bit
    logic [DW:0] shifted;
    logic        ge;
    logic [DW:0] diff;

    always_comb begin
      shifted = {rem[j], nlo[j][QW-1]};
      ge      = shifted >= {1'b0, dv[j]};
      diff    = shifted - {1'b0, dv[j]};
    end

    always_ff @(posedge clk) begin
      rem[j+1] <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      nlo[j+1] <= {nlo[j][QW-2:0], 1'b0};
      qq[j+1]  <= {qq[j][QW-2:0], ge};
      dv[j+1]  <= dv[j];
      bg[j+1]  <= bg[j];
    end
  end

  assign quot = qq[QW];
  assign big  = bg[QW];

endmodule

>>> hdl/gnp_back.sv
module gnp_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  gnp_pkg::gnp_item_t                item,
  input  logic [gnp_pkg::RAD_W-1:0]         radius,
  output logic                              out_valid,
  output logic signed [gnp_pkg::OUT_W-1:0]  east,
  output logic signed [gnp_pkg::OUT_W-1:0]  north,
  output logic [gnp_pkg::STAT_W-1:0]        status
);

  localparam int CL = gnp_pkg::CORD_LAT;
  localparam int DL = gnp_pkg::DIV_LAT;
  localparam int PW = gnp_pkg::PROD_W;
  localparam int XW = gnp_pkg::XY_W;
  localparam int QW = gnp_pkg::NQ_W;
  localparam int MW = gnp_pkg::MAG_W;
  localparam int OW = gnp_pkg::OUT_W;

  // magnitude of a signed q36 value
  function automatic logic [MW-1:0] magnitude(input logic signed [QW-1:0] v);
    return v[QW-1] ? MW'(-v) : MW'(v);
  endfunction

  // clamp, then apply sign; top bit flags saturation
  function automatic logic [OW:0] finish(input logic [OW-1:0] q, input logic ovf,
                                         input logic neg);
    logic [OW-1:0] lim;
    logic          sat;
    logic [OW-1:0] mag;
    lim = neg ? gnp_pkg::LIM_NEG : gnp_pkg::LIM_POS;
    sat = ovf || (q > lim);
    mag = sat ? lim : q;
    return {sat, neg ? -mag : mag};
  endfunction

  logic signed [XW-1:0] s0, c0, s1, c1, sd, cd;

  // three sine/cosine pipelines
  gnp_cordic u_cord_lat0 (.clk(clk), .angle(item.z0), .neg(item.neg0),
                          .sin_val(s0), .cos_val(c0));
  gnp_cordic u_cord_lat1 (.clk(clk), .angle(item.z1), .neg(item.neg1),
                          .sin_val(s1), .cos_val(c1));
  gnp_cordic u_cord_dlon (.clk(clk), .angle(item.zd), .neg(item.negd),
                          .sin_val(sd), .cos_val(cd));

  // side flags alongside the cordics
  logic [CL-1:0] c_valid;
  logic [CL-1:0] c_flip;
  logic [CL-1:0] c_pole;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= '0;
    end else begin
      c_valid <= {c_valid[CL-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    c_flip <= {c_flip[CL-2:0], item.flip};
    c_pole <= {c_pole[CL-2:0], item.pole};
  end

  // stage m1: first products
  logic                 m1_valid, m1_flip, m1_pole;
  logic signed [PW-1:0] p_cc, p_csd, p_c0s1, p_s0s1;
  logic signed [XW-1:0] m1_s0, m1_c0;

  always_ff @(posedge clk) begin
    p_cc   <= c1 * cd;
    p_csd  <= c1 * sd;
    p_c0s1 <= c0 * s1;
    p_s0s1 <= s0 * s1;
    m1_s0  <= s0;
    m1_c0  <= c0;
    m1_flip <= c_flip[CL-1];
    m1_pole <= c_pole[CL-1];
  end

  // stage m2: round cos(lat1)cos(dlon) to q30 and scale by centre terms
  logic signed [XW-1:0] t_q30;
  logic                 m2_valid, m2_flip, m2_pole;
  logic signed [PW-1:0] m2_csd, m2_c0s1, m2_s0s1, p_s0t, p_c0t;

  always_comb begin
    t_q30 = XW'((p_cc + gnp_pkg::RND30) >>> 30);
  end

  always_ff @(posedge clk) begin
    p_s0t   <= m1_s0 * t_q30;
    p_c0t   <= m1_c0 * t_q30;
    m2_csd  <= p_csd;
    m2_c0s1 <= p_c0s1;
    m2_s0s1 <= p_s0s1;
    m2_flip <= m1_flip;
    m2_pole <= m1_pole;
  end

  // stage m3: numerators and denominator in q36
  logic signed [PW-1:0] ny_sum, den_sum;
  logic signed [QW-1:0] nx, ny, den;
  logic                 m3_valid, m3_flip, m3_pole;

  always_comb begin
    ny_sum  = m2_c0s1 - p_s0t;
    den_sum = m2_s0s1 + p_c0t;
  end

  always_ff @(posedge clk) begin
    nx  <= QW'((m2_csd + gnp_pkg::RND24) >>> 24);
    ny  <= QW'((ny_sum + gnp_pkg::RND24) >>> 24);
    den <= QW'((den_sum + gnp_pkg::RND24) >>> 24);
    m3_flip <= m2_flip;
    m3_pole <= m2_pole;
  end

  // stage m4: scale by radius, settle signs
  logic [gnp_pkg::NUM_W-1:0] num_e, num_n;
  logic [MW-1:0]             ud;
  logic                      m4_valid;
  gnp_pkg::gnp_tag_t         m4_tag;

  always_ff @(posedge clk) begin
    num_e        <= radius * magnitude(nx);
    num_n        <= radius * magnitude(ny);
    ud           <= magnitude(den);
    m4_tag.pole  <= m3_pole;
    m4_tag.dz    <= (den == '0);
    m4_tag.neg_e <= nx[QW-1] ^ den[QW-1] ^ m3_flip;
    m4_tag.neg_n <= ny[QW-1] ^ den[QW-1] ^ m3_flip;
  end

  // valid bits through the multiply stages
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
      m4_valid <= 1'b0;
    end else begin
      m1_valid <= c_valid[CL-1];
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
      m4_valid <= m3_valid;
    end
  end

  // two dividers, east and north
  logic [OW-1:0] q_e, q_n;
  logic          big_e, big_n;

  gnp_div u_div_east  (.clk(clk), .num(num_e), .den(ud), .quot(q_e), .big(big_e));
  gnp_div u_div_north (.clk(clk), .num(num_n), .den(ud), .quot(q_n), .big(big_n));

  // flags alongside the dividers
  logic [DL-1:0]     d_valid;
  gnp_pkg::gnp_tag_t d_tag [DL];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= '0;
    end else begin
      d_valid <= {d_valid[DL-2:0], m4_valid};
    end
  end

  always_ff @(posedge clk) begin
    d_tag[0] <= m4_tag;
    for (int i = 1; i < DL; i++) begin
      d_tag[i] <= d_tag[i-1];
    end
  end

  // saturate and sign
  logic [OW:0]       res_e, res_n;
  gnp_pkg::gnp_tag_t tag_out;

  always_comb begin
    tag_out = d_tag[DL-1];
    res_e   = finish(q_e, big_e, tag_out.neg_e);
    res_n   = finish(q_n, big_n, tag_out.neg_n);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= d_valid[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (tag_out.pole) begin
      east   <= '0;
      north  <= '0;
      status <= gnp_pkg::STAT_POLE;
    end else if (tag_out.dz) begin
      east   <= '0;
      north  <= '0;
      status <= gnp_pkg::STAT_ZERO_DEN;
    end else begin
      east   <= $signed(res_e[OW-1:0]);
      north  <= $signed(res_n[OW-1:0]);
      status <= (res_e[OW] || res_n[OW]) ? gnp_pkg::STAT_SAT : gnp_pkg::STAT_OK;
    end
  end

endmodule

>>> hdl/gnomonic_projection_unit.sv
// each accepted word goes through the queue, the cordic pipelines, the multiply
// stages, the dividers and the result register; strobe is high while its result shows
// throughput: one word per cycle, sustained; the cordic and divider pipelines
// each take a new word every cycle, so busy stays low and no result waits
// the receiver cannot stall; each result shows for one cycle with strobe
// reset (rst, synchronous) empties the queue and the pipeline and sets
// sphere_radius back to 6371000
module gnomonic_projection_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [gnp_pkg::LAT_W-1:0]   centre_lat,
  input  logic signed [gnp_pkg::LON_W-1:0]   centre_lon,
  input  logic signed [gnp_pkg::LAT_W-1:0]   point_lat,
  input  logic signed [gnp_pkg::LON_W-1:0]   point_lon,
  output logic                               strobe,
  output logic signed [gnp_pkg::OUT_W-1:0]   east_metres,
  output logic signed [gnp_pkg::OUT_W-1:0]   north_metres,
  output logic [gnp_pkg::STAT_W-1:0]         status,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gnp_pkg::ADDR_W-1:0]         paddr,
  input  logic [gnp_pkg::DATA_W-1:0]         pwdata,
  output logic [gnp_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  logic [gnp_pkg::RAD_W-1:0] sphere_radius;
  logic                      reg_index;

  // register port
  assign pready    = 1'b1;
  assign reg_index = paddr[gnp_pkg::ADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= gnp_pkg::RADIUS_RESET;
    end else if (psel && penable && pwrite && pready && reg_index == gnp_pkg::REG_RADIUS) begin
      sphere_radius <= pwdata[gnp_pkg::RAD_W-1:0];
    end
  end

  always_comb begin
    if (reg_index == gnp_pkg::REG_RADIUS) begin
      prdata = {{(gnp_pkg::DATA_W-gnp_pkg::RAD_W){1'b0}}, sphere_radius};
    end else begin
      prdata = '0;
    end
  end

  // front end
  gnp_pkg::gnp_item_t front_item, queue_item;
  logic               push, q_empty, q_full, q_valid;

  gnp_front u_front (
    .start(start), .full(q_full),
    .centre_lat(centre_lat), .centre_lon(centre_lon),
    .point_lat(point_lat), .point_lon(point_lon),
    .push(push), .busy(busy), .item(front_item)
  );

  // queue between front and back
  gnp_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .pop(!q_empty),
    .din(front_item), .dout(queue_item), .dout_valid(q_valid),
    .empty(q_empty), .full(q_full)
  );

  // back end
  gnp_back u_back (
    .clk(clk), .rst(rst), .in_valid(q_valid), .item(queue_item),
    .radius(sphere_radius), .out_valid(strobe),
    .east(east_metres), .north(north_metres), .status(status)
  );

`include "gnomonic_projection_unit_assert.svh"

  `GNP_ASSERT_ALWAYS(a_never_busy, !busy)
  `GNP_ASSERT_LATENCY(a_latency, start && !busy, strobe)
  `GNP_ASSERT_IMPLY(a_pole_zero, strobe && status == gnp_pkg::STAT_POLE, east_metres == '0 && north_metres == '0)
  `GNP_ASSERT_IMPLY(a_den_zero, strobe && status == gnp_pkg::STAT_ZERO_DEN, east_metres == '0 && north_metres == '0)

endmodule
